### rtl/core/hd_pkg.sv
// Shared constants and elaboration-time helpers for the haversine distance block.
// Holds field widths, unit conversion constants and the CORDIC constant generators.
// Depends on nothing; hd_cordic_rot, hd_cordic_vec and haversine_distance refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hd_pkg;

   localparam int LAT_W       = 31;
   localparam int LON_W       = 32;
   localparam int DIST_W      = 32;
   localparam int RADIUS_W    = 23;
   localparam int RADIUS_CM_W = 30;
   localparam int WRAP_W      = 34;
   localparam int MAG_W       = 31;
   localparam int SCALE_W     = 43;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

   localparam logic signed [WRAP_W-1:0] TURN_UNITS         = 34'sd3600000000;
   localparam logic signed [WRAP_W-1:0] HALF_TURN_UNITS    = 34'sd1800000000;
   localparam logic [MAG_W-1:0]         HALF_TURN_MAG      = 31'd1800000000;
   localparam logic [MAG_W-1:0]         QUARTER_TURN_MAG   = 31'd900000000;
   localparam logic [SCALE_W-1:0]       HALF_RAD_SCALE     = 43'd4121042180595;
   localparam logic [SCALE_W-1:0]       FULL_RAD_SCALE     = 43'd8242084361190;
   localparam logic [63:0]              PI_QUARTER_Q62     = 64'd3622009729038561421;

   // Bitwise long division of 2^e by n, used only on constants.
   function automatic logic [63:0] div_pow2(input int e, input logic [63:0] n);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], (b == e) ? 1'b1 : 1'b0};
         if (rem >= {1'b0, n}) begin
            rem  = rem - {1'b0, n};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) from its odd power series in Q62, rounded half up to frac bits.
   function automatic logic [63:0] atan_q(input int i, input int frac);
      logic [63:0] acc;
      logic        sub;
      acc = '0;
      sub = 1'b0;
      if (i == 0) begin
         acc = PI_QUARTER_Q62;
      end else begin
         for (int n = 1; n <= 62; n += 2) begin
            if (i * n <= 62) begin
               if (sub) begin
                  acc = acc - div_pow2(62 - i * n, 64'(n));
               end else begin
                  acc = acc + div_pow2(62 - i * n, 64'(n));
               end
               sub = !sub;
            end
         end
      end
      return (acc + (64'd1 << (61 - frac))) >> (62 - frac);
   endfunction

   // 1/G^2 in frac fraction bits, floor, with the gain product kept in Q60.
   function automatic logic [63:0] inv_gain_sq(input int iter, input int frac);
      logic [63:0] p;
      logic [63:0] rem;
      logic [63:0] q;
      p   = 64'd1 << 60;
      rem = 64'd1 << 60;
      q   = '0;
      for (int i = 0; i < iter; i++) begin
         if (2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      for (int k = 0; k < frac; k++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= p) begin
            rem  = rem - p;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

endpackage

`default_nettype wire

### rtl/core/hd_mulsh.sv
// Two-stage rounding multiplier: magnitude product, round half up, shift, apply sign.
// The second operand is split in two halves so each partial product stays narrow.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module hd_mulsh #(
   parameter int AW = 31,
   parameter int BW = 43,
   parameter int SH = 42,
   parameter int OW = 34
) (
   input  wire                  clock,
   input  wire                  en,
   input  wire [AW-1:0]         a_mag,
   input  wire [BW-1:0]         b_mag,
   input  wire                  neg,
   output logic signed [OW-1:0] res
);

   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW + 1;

   logic [AW+BL-1:0] p_lo_ff;
   logic [AW+BH-1:0] p_hi_ff;
   logic             neg_ff;
   logic [PW-1:0]    full;
   logic [PW-1:0]    shifted;
   logic [PW-1:0]    signed_val;

   always_ff @(posedge clock) begin
      if (en) begin
         p_lo_ff <= (AW+BL)'(a_mag) * (AW+BL)'(b_mag[BL-1:0]);
         p_hi_ff <= (AW+BH)'(a_mag) * (AW+BH)'(b_mag[BW-1:BL]);
         neg_ff  <= neg;
      end
   end

   always_comb begin
      full       = PW'(p_lo_ff) + (PW'(p_hi_ff) << BL) + (PW'(1) << (SH - 1));
      shifted    = full >> SH;
      signed_val = neg_ff ? (~shifted + PW'(1)) : shifted;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res <= signed'(signed_val[OW-1:0]);
      end
   end

endmodule

`default_nettype wire

### rtl/core/hd_cordic_rot.sv
// Rotation-mode CORDIC, one register stage per iteration, starting at x = 1, y = 0.
// Outputs carry the CORDIC gain; a tag travels alongside the angle.
// Depends on hd_pkg for the arctangent constants.
`timescale 1ns / 1ps
`default_nettype none

module hd_cordic_rot #(
   parameter int ITER = 24,
   parameter int FRAC = 30,
   parameter int W    = 34,
   parameter int TW   = 1
) (
   input  wire                  clock,
   input  wire                  en,
   input  wire signed [W-1:0]   z_in,
   input  wire [TW-1:0]         tag_in,
   output logic signed [W-1:0]  x_out,
   output logic signed [W-1:0]  y_out,
   output logic [TW-1:0]        tag_out
);

   logic signed [W-1:0] x_ff [ITER];
   logic signed [W-1:0] y_ff [ITER];
   logic signed [W-1:0] z_ff [ITER];
   logic [TW-1:0]       tag_ff [ITER];

   for (genvar i = 0; i < ITER; i++) begin : g_stage
      localparam logic signed [W-1:0] AT = W'(hd_pkg::atan_q(i, FRAC));
      logic signed [W-1:0] xp, yp, zp;
      logic [TW-1:0]       tp;
      logic signed [W-1:0] x_in, y_in, z_in_s;

      if (i == 0) begin : g_first
         assign xp = W'(64'd1 << FRAC);
         assign yp = '0;
         assign zp = z_in;
         assign tp = tag_in;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign tp = tag_ff[i-1];
      end

      always_comb begin
         if (zp >= 0) begin
            x_in   = xp - (yp >>> i);
            y_in   = yp + (xp >>> i);
            z_in_s = zp - AT;
         end else begin
            x_in   = xp + (yp >>> i);
            y_in   = yp - (xp >>> i);
            z_in_s = zp + AT;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in_s;
            tag_ff[i] <= tp;
         end
      end
   end

   assign x_out   = x_ff[ITER-1];
   assign y_out   = y_ff[ITER-1];
   assign tag_out = tag_ff[ITER-1];

endmodule

`default_nettype wire

### rtl/core/hd_cordic_vec.sv
// Vectoring-mode CORDIC, one register stage per iteration, giving atan2(y, x).
// The angle accumulator starts at zero.
// Depends on hd_pkg for the arctangent constants.
`timescale 1ns / 1ps
`default_nettype none

module hd_cordic_vec #(
   parameter int ITER = 24,
   parameter int FRAC = 30,
   parameter int W    = 34
) (
   input  wire                 clock,
   input  wire                 en,
   input  wire signed [W-1:0]  x_in,
   input  wire signed [W-1:0]  y_in,
   output logic signed [W-1:0] z_out
);

   logic signed [W-1:0] x_ff [ITER];
   logic signed [W-1:0] y_ff [ITER];
   logic signed [W-1:0] z_ff [ITER];

   for (genvar i = 0; i < ITER; i++) begin : g_stage
      localparam logic signed [W-1:0] AT = W'(hd_pkg::atan_q(i, FRAC));
      logic signed [W-1:0] xp, yp, zp;
      logic signed [W-1:0] x_nx, y_nx, z_nx;

      if (i == 0) begin : g_first
         assign xp = x_in;
         assign yp = y_in;
         assign zp = '0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      always_comb begin
         if (yp >= 0) begin
            x_nx = xp + (yp >>> i);
            y_nx = yp - (xp >>> i);
            z_nx = zp + AT;
         end else begin
            x_nx = xp - (yp >>> i);
            y_nx = yp + (xp >>> i);
            z_nx = zp - AT;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_nx;
            y_ff[i] <= y_nx;
            z_ff[i] <= z_nx;
         end
      end
   end

   assign z_out = z_ff[ITER-1];

endmodule

`default_nettype wire

### rtl/core/hd_isqrt.sv
// Pipelined digit-by-digit square root: floor(sqrt(a * 2^FRAC)), one result bit per stage.
// The remainder is kept so that each stage needs one compare and one subtract.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module hd_isqrt #(
   parameter int FRAC = 30
) (
   input  wire              clock,
   input  wire              en,
   input  wire [FRAC:0]     a_in,
   output logic [FRAC:0]    root_out
);

   localparam int RW = 2 * FRAC + 2;

   logic [RW-1:0] rem_ff  [FRAC+1];
   logic [FRAC:0] root_ff [FRAC+1];

   for (genvar k = 0; k <= FRAC; k++) begin : g_stage
      localparam int B = FRAC - k;
      logic [RW-1:0] remp, trial, rem_nx;
      logic [FRAC:0] rp, root_nx;

      if (k == 0) begin : g_first
         assign remp = RW'({a_in, {FRAC{1'b0}}});
         assign rp   = '0;
      end else begin : g_next
         assign remp = rem_ff[k-1];
         assign rp   = root_ff[k-1];
      end

      // Trial square growth: 2 * r * 2^B + 4^B, the bits of r all lie above B.
      always_comb begin
         trial = (RW'(rp) << (B + 1)) | (RW'(1) << (2 * B));
         if (trial <= remp) begin
            rem_nx  = remp - trial;
            root_nx = rp | ((FRAC+1)'(1) << B);
         end else begin
            rem_nx  = remp;
            root_nx = rp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_nx;
            root_ff[k] <= root_nx;
         end
      end
   end

   assign root_out = root_ff[FRAC];

endmodule

`default_nettype wire

### rtl/core/haversine_distance.sv
// Haversine great-circle distance. Each request carries two points in 1e-7 degree and
// returns their distance in centimeters on a sphere whose radius in meters is set through
// the csr port (reset 6371000); results that do not fit 32 bits saturate to all ones.
// The pipeline accepts one request per clock while it is not stalled; its depth is set by
// the two CORDIC chains, one stage per iteration, and the square root, which settles one
// bit per stage. While a response waits with rsp_tready low the whole pipeline holds.
// Depends on hd_pkg, hd_mulsh, hd_cordic_rot, hd_cordic_vec and hd_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module haversine_distance #(
   parameter int CORDIC_ITERATIONS = 24,
   parameter int FRAC_BITS         = 30
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [127:0]                  req_tdata,   // lat_a, lon_a, lat_b, lon_b, zero pad
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [hd_pkg::DIST_W-1:0]    rsp_tdata,   // distance_cm
   input  wire                          csr_wr_en,
   input  wire [hd_pkg::RADIUS_W-1:0]   csr_wr_data  // earth_radius_m
);

   localparam int N       = CORDIC_ITERATIONS;
   localparam int W       = FRAC_BITS + 4;
   localparam int P       = FRAC_BITS + 5;
   localparam int LAT     = 2 * N + FRAC_BITS + 15;
   localparam int IDX_A   = N + 11;
   localparam int IDX_RT  = N + FRAC_BITS + 12;
   localparam int OUT_W   = hd_pkg::DIST_W + 4;
   localparam logic [P-1:0] K2 = P'(hd_pkg::inv_gain_sq(N, FRAC_BITS));
   localparam logic signed [P:0] ONE_S =
      {{(P - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};

   logic adv;
   logic [LAT-1:0] vld_ff, vld_in;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign vld_in     = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Radius register and its value in centimeters.
   logic [hd_pkg::RADIUS_W-1:0]    radius_ff;
   logic [hd_pkg::RADIUS_CM_W-1:0] radius_cm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= hd_pkg::RADIUS_RESET;
         radius_cm_ff <= hd_pkg::RADIUS_CM_W'(hd_pkg::RADIUS_RESET) * 30'd100;
      end else begin
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
         radius_cm_ff <= hd_pkg::RADIUS_CM_W'(radius_ff) * 30'd100;
      end
   end

   // Stage 1: differences wrapped to a half turn, latitudes folded into a quarter turn.
   function automatic logic signed [hd_pkg::WRAP_W-1:0] wrap_units(
      input logic signed [hd_pkg::WRAP_W-1:0] d);
      logic signed [hd_pkg::WRAP_W-1:0] r;
      r = d;
      if (d > hd_pkg::HALF_TURN_UNITS) begin
         r = d - hd_pkg::TURN_UNITS;
      end else if (d <= -hd_pkg::HALF_TURN_UNITS) begin
         r = d + hd_pkg::TURN_UNITS;
      end
      return r;
   endfunction

   logic signed [hd_pkg::LAT_W-1:0]  lat_a, lat_b;
   logic signed [hd_pkg::LON_W-1:0]  lon_a, lon_b;
   logic signed [hd_pkg::WRAP_W-1:0] dlat_w, dlon_w;
   logic [hd_pkg::MAG_W-1:0]         mag_in [4];
   logic [3:0]                       sgn_in;
   logic [1:0]                       cneg_in;
   logic [hd_pkg::MAG_W-1:0]         mag_ff [4];
   logic [3:0]                       sgn_ff;
   logic [1:0]                       cneg_ff, cneg1_ff, cneg2_ff;
   logic signed [hd_pkg::LAT_W:0]    lat_ext [2];
   logic [hd_pkg::MAG_W-1:0]         lat_mag [2];

   assign lat_a = signed'(req_tdata[30:0]);
   assign lon_a = signed'(req_tdata[62:31]);
   assign lat_b = signed'(req_tdata[93:63]);
   assign lon_b = signed'(req_tdata[125:94]);

   always_comb begin
      dlat_w     = wrap_units(hd_pkg::WRAP_W'(lat_b) - hd_pkg::WRAP_W'(lat_a));
      dlon_w     = wrap_units(hd_pkg::WRAP_W'(lon_b) - hd_pkg::WRAP_W'(lon_a));
      mag_in[0]  = dlat_w[hd_pkg::WRAP_W-1] ? hd_pkg::MAG_W'(-dlat_w)
                                            : hd_pkg::MAG_W'(dlat_w);
      mag_in[1]  = dlon_w[hd_pkg::WRAP_W-1] ? hd_pkg::MAG_W'(-dlon_w)
                                            : hd_pkg::MAG_W'(dlon_w);
      sgn_in     = {2'b00, dlon_w[hd_pkg::WRAP_W-1], dlat_w[hd_pkg::WRAP_W-1]};
      lat_ext[0] = (hd_pkg::LAT_W+1)'(lat_a);
      lat_ext[1] = (hd_pkg::LAT_W+1)'(lat_b);
      for (int j = 0; j < 2; j++) begin
         lat_mag[j] = lat_ext[j][hd_pkg::LAT_W] ? hd_pkg::MAG_W'(-lat_ext[j])
                                                : hd_pkg::MAG_W'(lat_ext[j]);
         // Past a quarter turn the cosine is taken of the supplement and negated.
         cneg_in[j] = lat_mag[j] > hd_pkg::QUARTER_TURN_MAG;
         mag_in[j+2] = cneg_in[j] ? hd_pkg::HALF_TURN_MAG - lat_mag[j] : lat_mag[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            mag_ff[j] <= mag_in[j];
         end
         sgn_ff   <= sgn_in;
         cneg_ff  <= cneg_in;
         cneg1_ff <= cneg_ff;
         cneg2_ff <= cneg1_ff;
      end
   end

   // Stages 2-3 scale to radians, then the four sine and cosine chains.
   logic signed [W-1:0] ang [4];
   logic signed [W-1:0] rx [4];
   logic signed [W-1:0] ry [4];
   logic [0:0]          rtag [4];
   logic [0:0]          tag_in [4];

   assign tag_in[0] = 1'b0;
   assign tag_in[1] = 1'b0;
   assign tag_in[2] = cneg2_ff[0];
   assign tag_in[3] = cneg2_ff[1];

   for (genvar j = 0; j < 4; j++) begin : g_angle
      hd_mulsh #(
         .AW(hd_pkg::MAG_W), .BW(hd_pkg::SCALE_W), .SH(72 - FRAC_BITS), .OW(W)
      ) u_scale (
         .clock(clock), .en(adv), .a_mag(mag_ff[j]),
         .b_mag((j < 2) ? hd_pkg::HALF_RAD_SCALE : hd_pkg::FULL_RAD_SCALE),
         .neg(sgn_ff[j]), .res(ang[j])
      );
      hd_cordic_rot #(.ITER(N), .FRAC(FRAC_BITS), .W(W), .TW(1)) u_rot (
         .clock(clock), .en(adv), .z_in(ang[j]), .tag_in(tag_in[j]),
         .x_out(rx[j]), .y_out(ry[j]), .tag_out(rtag[j])
      );
   end

   // Squared half-angle sines and the product of the latitude cosines.
   logic [W-1:0] s1_mag, s2_mag, ca_mag, cb_mag;
   logic         cc_neg;
   logic signed [P-1:0] s1sq, s2sq, cc;

   always_comb begin
      s1_mag = ry[0][W-1] ? W'(-ry[0]) : W'(ry[0]);
      s2_mag = ry[1][W-1] ? W'(-ry[1]) : W'(ry[1]);
      ca_mag = rx[2][W-1] ? W'(-rx[2]) : W'(rx[2]);
      cb_mag = rx[3][W-1] ? W'(-rx[3]) : W'(rx[3]);
      cc_neg = rtag[2][0] ^ rtag[3][0] ^ rx[2][W-1] ^ rx[3][W-1];
   end

   hd_mulsh #(.AW(W), .BW(W), .SH(FRAC_BITS), .OW(P)) u_s1sq (
      .clock(clock), .en(adv), .a_mag(s1_mag), .b_mag(s1_mag), .neg(1'b0), .res(s1sq));
   hd_mulsh #(.AW(W), .BW(W), .SH(FRAC_BITS), .OW(P)) u_s2sq (
      .clock(clock), .en(adv), .a_mag(s2_mag), .b_mag(s2_mag), .neg(1'b0), .res(s2sq));
   hd_mulsh #(.AW(W), .BW(W), .SH(FRAC_BITS), .OW(P)) u_cc (
      .clock(clock), .en(adv), .a_mag(ca_mag), .b_mag(cb_mag), .neg(cc_neg), .res(cc));

   // Gain correction chain: t1 = k2 s1^2, t4 = k2 k2 cc s2^2.
   logic signed [P-1:0] t1, t2, t3, t4;
   logic [P-1:0] s1sq_mag, s2sq_mag, cc_mag, t2_mag, t3_mag;

   assign s1sq_mag = s1sq[P-1] ? P'(-s1sq) : P'(s1sq);
   assign s2sq_mag = s2sq[P-1] ? P'(-s2sq) : P'(s2sq);
   assign cc_mag   = cc[P-1] ? P'(-cc) : P'(cc);
   assign t2_mag   = t2[P-1] ? P'(-t2) : P'(t2);
   assign t3_mag   = t3[P-1] ? P'(-t3) : P'(t3);

   hd_mulsh #(.AW(P), .BW(P), .SH(FRAC_BITS), .OW(P)) u_t1 (
      .clock(clock), .en(adv), .a_mag(K2), .b_mag(s1sq_mag), .neg(s1sq[P-1]), .res(t1));
   hd_mulsh #(.AW(P), .BW(P), .SH(FRAC_BITS), .OW(P)) u_t2 (
      .clock(clock), .en(adv), .a_mag(cc_mag), .b_mag(s2sq_mag),
      .neg(cc[P-1] ^ s2sq[P-1]), .res(t2));
   hd_mulsh #(.AW(P), .BW(P), .SH(FRAC_BITS), .OW(P)) u_t3 (
      .clock(clock), .en(adv), .a_mag(K2), .b_mag(t2_mag), .neg(t2[P-1]), .res(t3));
   hd_mulsh #(.AW(P), .BW(P), .SH(FRAC_BITS), .OW(P)) u_t4 (
      .clock(clock), .en(adv), .a_mag(K2), .b_mag(t3_mag), .neg(t3[P-1]), .res(t4));

   logic signed [P-1:0] t1_dly_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_dly_ff[0] <= t1;
         for (int j = 1; j < 4; j++) begin
            t1_dly_ff[j] <= t1_dly_ff[j-1];
         end
      end
   end

   // Haversine term clamped to [0, 1], and its complement.
   logic signed [P:0]    a_sum;
   logic [FRAC_BITS:0]   a_in, oma_in, a_ff, oma_ff;

   always_comb begin
      a_sum = (P+1)'(t1_dly_ff[3]) + (P+1)'(t4);
      if (a_sum < 0) begin
         a_in = '0;
      end else if (a_sum > ONE_S) begin
         a_in = ONE_U;
      end else begin
         a_in = a_sum[FRAC_BITS:0];
      end
      oma_in = ONE_U - a_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff   <= a_in;
         oma_ff <= oma_in;
      end
   end

   logic [FRAC_BITS:0] root_a, root_oma;

   hd_isqrt #(.FRAC(FRAC_BITS)) u_sqrt_a (
      .clock(clock), .en(adv), .a_in(a_ff), .root_out(root_a));
   hd_isqrt #(.FRAC(FRAC_BITS)) u_sqrt_oma (
      .clock(clock), .en(adv), .a_in(oma_ff), .root_out(root_oma));

   logic signed [W-1:0] vz;

   hd_cordic_vec #(.ITER(N), .FRAC(FRAC_BITS), .W(W)) u_vec (
      .clock(clock), .en(adv),
      .x_in(signed'(W'(root_oma))), .y_in(signed'(W'(root_a))), .z_out(vz));

   // Central angle is twice the vectoring result, never negative.
   logic [W-1:0]            c_mag;
   logic signed [OUT_W-1:0] dist_full;

   assign c_mag = vz[W-1] ? '0 : {vz[W-2:0], 1'b0};

   hd_mulsh #(.AW(hd_pkg::RADIUS_CM_W), .BW(W), .SH(FRAC_BITS), .OW(OUT_W)) u_dist (
      .clock(clock), .en(adv), .a_mag(radius_cm_ff), .b_mag(c_mag), .neg(1'b0),
      .res(dist_full));

   assign rsp_tdata = (|dist_full[OUT_W-1:hd_pkg::DIST_W]) ? '1
                                                          : dist_full[hd_pkg::DIST_W-1:0];

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff == $past(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_radius_write: assert property (@(posedge clock) disable iff (reset)
      $past(csr_wr_en) && !$past(reset) |-> radius_ff == $past(csr_wr_data))
      else $error("radius register missed a write");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IDX_RT] |-> root_a <= ONE_U && root_oma <= ONE_U)
      else $error("square root above one");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IDX_A] |-> a_ff <= ONE_U)
      else $error("haversine term above one");

endmodule

`default_nettype wire
